FILE: hdl/assert_macros.svh
// Assertion helpers for the console writer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int BYTE_W = 8;

   localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(SCREEN_ROWS);
   localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(SCREEN_COLUMNS);
   localparam logic [ADDR_W-1:0] COLS_ADDR  = ADDR_W'(SCREEN_COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);

   localparam logic              CMD_PRINT    = 1'b0;
   localparam logic              CMD_READ     = 1'b1;
   localparam logic [BYTE_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CODE_RETURN  = 8'd13;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } tcw_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
      logic [ROW_W-1:0]  cursor_row_out;
      logic [COL_W-1:0]  cursor_col_out;
   } tcw_rsp_type;

   // Attribute in the high byte, character in the low byte.
   typedef struct packed {
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] chr;
   } tcw_cell_type;

   typedef struct packed {
      logic         wr_en;
      logic [ADDR_W-1:0] wr_addr;
      tcw_cell_type wr_data;
      logic         rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tcw_ram_req_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRINT,
      ST_SCROLL,
      ST_SCROLL_END,
      ST_REPLY
   } tcw_state_type;

endpackage

`default_nettype wire

FILE: hdl/tcw_screen_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram (
   input  wire logic                     clock,
   input  wire tcw_pkg::tcw_ram_req_type ram_req,
   output tcw_pkg::tcw_cell_type         rd_data
);
   import tcw_pkg::*;

   tcw_cell_type mem [CELL_COUNT];
   tcw_cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcw_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire tcw_pkg::tcw_req_type     req_data,
   input  wire logic [7:0]               attr,
   output logic                          reply_valid,
   input  wire logic                     reply_ready,
   output tcw_pkg::tcw_rsp_type          reply_data,
   output tcw_pkg::tcw_ram_req_type      ram_req,
   input  wire tcw_pkg::tcw_cell_type    ram_rdata
);
   import tcw_pkg::*;

   tcw_state_type     state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [BYTE_W-1:0] code_ff, code_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              wr_fill_ff, wr_fill_in;
   logic              use_cell_ff, use_cell_in;

   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [ADDR_W-1:0] cell_addr;
   logic              read_in_range;
   logic              copy_phase;

   // Shared address unit: row times screen width plus column.
   assign sel_row   = (state_ff == ST_IDLE) ? req_data.read_row : row_ff;
   assign sel_col   = (state_ff == ST_IDLE) ? req_data.read_col : col_ff;
   assign cell_addr = ADDR_W'(sel_row) * COLS_ADDR + ADDR_W'(sel_col);

   assign read_in_range = (req_data.read_row < ROW_LIMIT) && (req_data.read_col < COL_LIMIT);
   assign copy_phase    = (sweep_ff < FILL_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         row_ff     <= '0;
         col_ff     <= '0;
         sweep_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         sweep_ff   <= sweep_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      wr_addr_ff  <= wr_addr_in;
      wr_fill_ff  <= wr_fill_in;
      use_cell_ff <= use_cell_in;
   end

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      code_in     = code_ff;
      sweep_in    = sweep_ff;
      wr_pend_in  = 1'b0;
      wr_addr_in  = wr_addr_ff;
      wr_fill_in  = wr_fill_ff;
      use_cell_in = use_cell_ff;
      req_ready   = 1'b0;
      reply_valid = 1'b0;
      ram_req     = '0;

      // A scroll write issued last cycle owns the write port this cycle.
      if (wr_pend_ff) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = wr_addr_ff;
         ram_req.wr_data = wr_fill_ff ? tcw_cell_type'({attr, BYTE_W'(0)}) : ram_rdata;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = sweep_ff;
            ram_req.wr_data = '0;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               code_in = req_data.char_code;
               if (req_data.command == CMD_READ) begin
                  use_cell_in     = read_in_range;
                  ram_req.rd_en   = read_in_range;
                  ram_req.rd_addr = cell_addr;
                  state_in        = ST_REPLY;
               end else begin
                  use_cell_in = 1'b0;
                  state_in    = ST_PRINT;
               end
            end
         end
         ST_PRINT: begin
            if (row_ff >= ROW_LIMIT) begin
               sweep_in = '0;
               state_in = ST_SCROLL;
            end else if (code_ff == CODE_NEWLINE) begin
               row_in   = row_ff + ROW_W'(1);
               col_in   = '0;
               state_in = ST_REPLY;
            end else if (code_ff == CODE_RETURN) begin
               col_in   = '0;
               state_in = ST_REPLY;
            end else if (col_ff >= COL_LIMIT) begin
               // Wrap, then decide again: a row past the bottom scrolls.
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = cell_addr;
               ram_req.wr_data = tcw_cell_type'({attr, code_ff});
               col_in          = col_ff + COL_W'(1);
               state_in        = ST_REPLY;
            end
         end
         ST_SCROLL: begin
            ram_req.rd_en   = copy_phase;
            ram_req.rd_addr = sweep_ff + COLS_ADDR;
            wr_pend_in      = 1'b1;
            wr_addr_in      = sweep_ff;
            wr_fill_in      = !copy_phase;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_SCROLL_END;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ST_SCROLL_END: begin
            if (row_ff != '0) begin
               row_in = row_ff - ROW_W'(1);
            end
            col_in   = '0;
            state_in = ST_PRINT;
         end
         ST_REPLY: begin
            reply_valid = 1'b1;
            if (reply_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      reply_data                = '0;
      reply_data.cursor_row_out = row_ff;
      reply_data.cursor_col_out = col_ff;
      if (use_cell_ff) begin
         reply_data.cell_char = ram_rdata.chr;
         reply_data.cell_attr = ram_rdata.attr;
      end
   end

   `ASSERT_ALWAYS(a_row_bound, clock, reset, row_ff <= ROW_LIMIT,
                  "cursor row beyond screen height")
   `ASSERT_ALWAYS(a_col_bound, clock, reset, col_ff <= COL_LIMIT,
                  "cursor column beyond screen width")
   `ASSERT_IMPLIES(a_wr_range, clock, reset, ram_req.wr_en, ram_req.wr_addr <= LAST_CELL,
                   "screen write outside the store")
   `ASSERT_NEXT(a_scroll_row, clock, reset, state_ff == ST_SCROLL_END,
                row_ff == $past(row_ff) - ROW_W'(1) && col_ff == '0,
                "scroll did not move the cursor up one row")
   `ASSERT_IMPLIES(a_idle_quiet, clock, reset, state_ff == ST_IDLE || state_ff == ST_REPLY,
                   !wr_pend_ff, "scroll write still pending outside the sweep")

endmodule

`default_nettype wire

FILE: hdl/text_console_writer.sv
// Each word runs through the sequencer states: a read word from idle to reply, a printed
// byte from idle to print to reply, with a wrap to the next row and a scroll pass over
// the store first where needed. A new word is taken only in idle, once the last result
// has entered the output register; the sequencer walks the store's single write port.
// Reset (synchronous): cursor to 0,0, attribute to 15, then a clearing pass over the
// screen store during which no input word is taken; configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tcw_pkg::tcw_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tcw_pkg::tcw_rsp_type      rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [7:0]           csr_data
);
   import tcw_pkg::*;

   // Attribute register: stored with every printed byte and used as the
   // blank fill of the bottom row after a scroll.
   logic [BYTE_W-1:0] attr_ff, attr_in;

   // Output register. It lets the controller finish the next word while a
   // result still waits to be taken.
   logic        rsp_valid_ff, rsp_valid_in;
   tcw_rsp_type rsp_data_ff, rsp_data_in;

   logic            reply_valid;
   logic            reply_ready;
   tcw_rsp_type     reply_data;
   tcw_ram_req_type ram_req;
   tcw_cell_type    ram_rdata;

   // The sequencer walks the screen store for clearing and scrolling and
   // drives the cursor; the store itself is a plain one-write, one-read RAM.
   tcw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .attr        (attr_ff),
      .reply_valid (reply_valid),
      .reply_ready (reply_ready),
      .reply_data  (reply_data),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata)
   );

   tcw_screen_ram u_screen_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   // The attribute can be written at any time; it is only sampled by the
   // sequencer while a word is in progress.
   assign csr_ready = 1'b1;

   always_comb begin
      attr_in = attr_ff;
      if (csr_valid) begin
         attr_in = csr_data;
      end
   end

   // The slot is free when empty or when its word leaves this cycle.
   assign reply_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (reply_valid && reply_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = reply_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= BYTE_W'(15);
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: tb/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  tcw_pkg::tcw_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tcw_pkg::tcw_rsp_type rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [7:0]           csr_data,
   output int                   fail_count,
   output int                   pending_count
);
   import tcw_pkg::*;

   tcw_cell_type     shadow_screen [CELL_COUNT];
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] cur_col;
   logic [7:0]       text_attr;
   tcw_rsp_type      expected_replies [$];
   tcw_rsp_type      want;
   tcw_rsp_type      got_reply;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Every row moves up one place; the bottom row becomes blanks in the current attribute.
   task automatic scroll_screen();
      for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++) begin
         shadow_screen[i] = shadow_screen[i + SCREEN_COLUMNS];
      end
      for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++) begin
         shadow_screen[i] = {text_attr, 8'h00};
      end
      if (cur_row > 0) begin
         cur_row = cur_row - 1'b1;
      end
      cur_col = '0;
   endtask

   task automatic predict_reply(input tcw_req_type w, output tcw_rsp_type r);
      int           idx;
      tcw_cell_type screen_entry;
      r = '0;
      if (w.command == CMD_PRINT) begin
         if (cur_row >= ROW_LIMIT) begin
            scroll_screen();
         end
         if (w.char_code == CODE_NEWLINE) begin
            cur_row = cur_row + 1'b1;
            cur_col = '0;
         end else if (w.char_code == CODE_RETURN) begin
            cur_col = '0;
         end else begin
            if (cur_col >= COL_LIMIT) begin
               cur_col = '0;
               cur_row = cur_row + 1'b1;
               if (cur_row >= ROW_LIMIT) begin
                  scroll_screen();
               end
            end
            idx = cur_row * SCREEN_COLUMNS + cur_col;
            if (idx < CELL_COUNT) begin
               shadow_screen[idx] = {text_attr, w.char_code};
            end
            cur_col = cur_col + 1'b1;
         end
      end else if (w.read_row < ROW_LIMIT && w.read_col < COL_LIMIT) begin
         screen_entry = shadow_screen[w.read_row * SCREEN_COLUMNS + w.read_col];
         r.cell_char = screen_entry.chr;
         r.cell_attr = screen_entry.attr;
      end
      r.cursor_row_out = cur_row;
      r.cursor_col_out = cur_col;
   endtask

   task automatic check_field(input string name, input int expected_value,
                              input int actual_value);
      if (expected_value != actual_value) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected_value, actual_value);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELL_COUNT; i++) begin
            shadow_screen[i] = '0;
         end
         cur_row   = '0;
         cur_col   = '0;
         text_attr = 8'd15;
         expected_replies.delete();
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_reply = rsp_data;
            if (expected_replies.size() == 0) begin
               $error("unexpected result word: row %0d col %0d", got_reply.cursor_row_out,
                      got_reply.cursor_col_out);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("cell_char", int'(want.cell_char), int'(got_reply.cell_char));
               check_field("cell_attr", int'(want.cell_attr), int'(got_reply.cell_attr));
               check_field("cursor_row_out", int'(want.cursor_row_out),
                           int'(got_reply.cursor_row_out));
               check_field("cursor_col_out", int'(want.cursor_col_out),
                           int'(got_reply.cursor_col_out));
            end
         end
         if (csr_valid && csr_ready) begin
            text_attr = csr_data;
         end
         if (req_valid && req_ready) begin
            predict_reply(req_data, want);
            expected_replies.push_back(want);
         end
         pending_count = expected_replies.size();
      end
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   // The run is bounded by scrolls: each one walks the whole store. A busy run
   // sees perhaps 150 of them plus the worst stalls on every word, and the
   // clearing pass after reset; the limit leaves a wide margin over that.
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_WORDS  = 235;
   localparam int DRAIN_CYCLES = 16;

   // Kinds of text the random part produces. Short lines exercise newline and scrolling,
   // long lines run the column to the right edge so that wrapping happens, and byte noise
   // throws arbitrary codes and arbitrary read positions at the block.
   typedef enum int {
      TEXT_LINES,
      LONG_LINES,
      BYTE_NOISE
   } text_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   tcw_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   tcw_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'h00;

   // When set, neither side inserts any idle cycles, so the block runs back to back.
   logic        burst_mode = 1'b0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_console_writer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   tcw_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // A print word; the read fields are don't-care for the block, so they carry noise.
   function automatic tcw_req_type print_word(input logic [7:0] code);
      tcw_req_type w;
      w.command   = CMD_PRINT;
      w.char_code = code;
      w.read_row  = ROW_W'($urandom_range(0, 31));
      w.read_col  = COL_W'($urandom_range(0, 127));
      return w;
   endfunction

   // A read word; the character field is ignored, so it carries noise.
   function automatic tcw_req_type read_word(input int row, input int col);
      tcw_req_type w;
      w.command   = CMD_READ;
      w.char_code = BYTE_W'($urandom_range(0, 255));
      w.read_row  = ROW_W'(row);
      w.read_col  = COL_W'(col);
      return w;
   endfunction

   // Draws one random word in the style of the current text mode. Reads mostly land on the
   // screen, with a share of positions past the last row or column; in byte noise mode the
   // positions and codes are entirely arbitrary.
   function automatic tcw_req_type make_word(input text_mode_type mode);
      tcw_req_type w;
      int          pick;
      int          read_share;
      read_share = (mode == LONG_LINES) ? 15 : 35;
      if ($urandom_range(0, 99) < read_share) begin
         w = read_word($urandom_range(0, 31), $urandom_range(0, 127));
         if (mode != BYTE_NOISE && $urandom_range(0, 99) < 85) begin
            w.read_row = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
            w.read_col = COL_W'($urandom_range(0, SCREEN_COLUMNS - 1));
         end
      end else begin
         w    = print_word(BYTE_W'($urandom_range(0, 255)));
         pick = $urandom_range(0, 99);
         if (mode == TEXT_LINES) begin
            if (pick < 15) begin
               w.char_code = CODE_NEWLINE;
            end else if (pick < 19) begin
               w.char_code = CODE_RETURN;
            end
         end else if (mode == LONG_LINES) begin
            if (pick < 1) begin
               w.char_code = CODE_NEWLINE;
            end else if (pick < 2) begin
               w.char_code = CODE_RETURN;
            end
         end
      end
      return w;
   endfunction

   // Offers one word on the request channel. It is entered at a falling edge and returns at
   // the falling edge after the word was taken, with valid still high; the caller either
   // sends the next word or drops valid at once.
   task automatic send_word(input tcw_req_type w);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Lets every outstanding result come back. Since each word yields exactly one result,
   // an empty expectation queue means the block is idle.
   task automatic wait_for_idle();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Writes the attribute register while the block is idle.
   task automatic write_attribute(input logic [7:0] value);
      wait_for_idle();
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // The result side draws its own stall before each word it takes, independent of when
   // the block happens to produce one, so stalls land on every stage of the block's work.
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = burst_mode ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int            seg_left;
      text_mode_type mode;
      logic [7:0]    attr_value;

      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part, first with the attribute left at its reset value. The block is busy
      // clearing its store right after reset; the first word simply waits for ready.
      send_word(read_word(0, 0));
      send_word(print_word(8'h00));
      send_word(print_word(8'hFF));
      send_word(print_word(8'h41));
      send_word(print_word(CODE_RETURN));
      // The carriage return brings the column back, so this overwrites the first cell.
      send_word(print_word(8'h42));
      send_word(read_word(0, 0));
      send_word(read_word(0, 1));
      send_word(read_word(0, 2));
      send_word(print_word(CODE_NEWLINE));
      send_word(read_word(SCREEN_ROWS - 1, SCREEN_COLUMNS - 1));
      // Reads past the last row or past the last column return an empty cell.
      send_word(read_word(SCREEN_ROWS, 0));
      send_word(read_word(0, SCREEN_COLUMNS));
      send_word(read_word(31, 127));

      write_attribute(8'hFF);
      send_word(print_word(8'h7F));
      send_word(read_word(1, 0));

      write_attribute(8'h00);
      send_word(print_word(CODE_RETURN));
      send_word(print_word(8'h01));
      send_word(read_word(1, 0));
      send_word(print_word(CODE_NEWLINE));
      send_word(print_word(CODE_NEWLINE));
      send_word(read_word(2, 0));

      // Random part: several phases, each behind an attribute write taken while the block
      // is idle. The wait before every write is also where the sender holds off until all
      // expected results are back. Two phases run with no idle cycles on either side.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: attr_value = 8'h00;
            1: attr_value = 8'hFF;
            3: attr_value = 8'h80;
            5: attr_value = 8'h01;
            default: attr_value = BYTE_W'($urandom_range(0, 255));
         endcase
         write_attribute(attr_value);
         burst_mode = (phase == 2 || phase == 5);
         seg_left   = 0;
         mode       = TEXT_LINES;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Text comes in segments of one style; long segments give the long-line style
            // enough characters to run off the right edge.
            if (seg_left == 0) begin
               seg_left = $urandom_range(40, 200);
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6, 7, 8: mode = TEXT_LINES;
                  9, 10, 11, 12, 13, 14, 15: mode = LONG_LINES;
                  default:                   mode = BYTE_NOISE;
               endcase
            end
            seg_left--;
            send_word(make_word(mode));
         end
      end

      // Drain: everything sent must come back, and nothing further may appear after it.
      wait_for_idle();
      burst_mode = 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
tb/tcw_checker.sv
tb/tb_top.sv
